// ===== hdl/stcw_pkg.sv =====
`timescale 1ns / 1ps

package stcw_pkg;

    // Datapath widths after normalization (largest offset magnitude in [2^31, 2^32))
    localparam int CW = 36;   // CORDIC x/y
    localparam int AW = 34;   // binary angles, normalized offsets

    localparam int ANG_TABLE_LEN = 24;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [27:0] INV_GAIN_Q28 = 28'd163008219;

    localparam logic signed [AW-1:0] HALF_TURN    = 34'sh0_8000_0000;
    localparam logic signed [AW-1:0] QUARTER_TURN = 34'sh0_4000_0000;

    // atan(2^-i) with a full turn of 2^32
    localparam logic signed [AW-1:0] ATAN_BAM [ANG_TABLE_LEN] = '{
        34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4,
        34'sh028B0D43, 34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55,
        34'sh0028BE53, 34'sh00145F2F, 34'sh000A2F98, 34'sh000517CC,
        34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA, 34'sh0000517D,
        34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
        34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic degen;      // offset is zero
        logic yaxis;      // dx == dz == 0
        logic pitch_up;   // dy > 0
    } flags_t;

    // x, y: vector under rotation; z: angle accumulator;
    // aux: dy during yaw, finished yaw during pitch
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] z;
        logic signed [AW-1:0] aux;
        flags_t               flags;
    } cordic_t;

endpackage

// ===== hdl/stcw_front.sv =====
`timescale 1ns / 1ps

module stcw_front import stcw_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic signed [COORD_BITS-1:0] center_z,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output cordic_t                      out_data
);

    localparam int DW = COORD_BITS + 1;

    function automatic logic [2:0] lzc8(input logic [7:0] b);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = 3'(7 - i);
        end
        return r;
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic r1, r2, r3, r4, r5;

    assign r5 = !v5_reg || out_ready;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: offset from center
    logic signed [DW-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic signed [DW-1:0] dx1_next, dy1_next, dz1_next;

    assign dx1_next = DW'(point_x) - DW'(center_x);
    assign dy1_next = DW'(point_y) - DW'(center_y);
    assign dz1_next = DW'(point_z) - DW'(center_z);

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) begin
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;
            dz1_reg <= dz1_next;
        end
    end

    // Stage 2: OR of magnitudes has the same leading-zero count as the max
    logic signed [DW-1:0] dx2_reg, dy2_reg, dz2_reg;
    logic signed [DW-1:0] ax, ay, az;
    logic [COORD_BITS-1:0] mag2_reg, mag2_next;
    flags_t flags2_reg, flags2_next;

    always_comb begin
        ax = dx1_reg[DW-1] ? -dx1_reg : dx1_reg;
        ay = dy1_reg[DW-1] ? -dy1_reg : dy1_reg;
        az = dz1_reg[DW-1] ? -dz1_reg : dz1_reg;
        mag2_next = ax[COORD_BITS-1:0] | ay[COORD_BITS-1:0] | az[COORD_BITS-1:0];
        flags2_next.yaxis    = (dx1_reg == '0) && (dz1_reg == '0);
        flags2_next.degen    = flags2_next.yaxis && (dy1_reg == '0);
        flags2_next.pitch_up = !dy1_reg[DW-1] && (dy1_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (r2 && v1_reg) begin
            dx2_reg    <= dx1_reg;
            dy2_reg    <= dy1_reg;
            dz2_reg    <= dz1_reg;
            mag2_reg   <= mag2_next;
            flags2_reg <= flags2_next;
        end
    end

    // Stage 3: per-byte leading-zero counts
    logic signed [DW-1:0] dx3_reg, dy3_reg, dz3_reg;
    logic [31:0] mag32;
    logic [3:0]  nz3_reg, nz3_next;
    logic [2:0]  lz3_reg [4];
    logic [2:0]  lz3_next [4];
    flags_t      flags3_reg;

    always_comb begin
        mag32 = 32'(mag2_reg);
        for (int k = 0; k < 4; k++) begin
            nz3_next[k] = |mag32[8*k +: 8];
            lz3_next[k] = lzc8(mag32[8*k +: 8]);
        end
    end

    always_ff @(posedge aclk) begin
        if (r3 && v2_reg) begin
            dx3_reg    <= dx2_reg;
            dy3_reg    <= dy2_reg;
            dz3_reg    <= dz2_reg;
            nz3_reg    <= nz3_next;
            lz3_reg    <= lz3_next;
            flags3_reg <= flags2_reg;
        end
    end

    // Stage 4: pick the top nonzero byte, then shift all three components
    logic [4:0] shamt;
    logic signed [AW-1:0] dx4_reg, dy4_reg, dz4_reg;
    logic signed [AW-1:0] dx4_next, dy4_next, dz4_next;
    flags_t flags4_reg;

    always_comb begin
        shamt = 5'd0;
        for (int k = 0; k < 4; k++) begin
            if (nz3_reg[k]) shamt = 5'((3 - k) * 8) + 5'(lz3_reg[k]);
        end
        dx4_next = AW'(dx3_reg) <<< shamt;
        dy4_next = AW'(dy3_reg) <<< shamt;
        dz4_next = AW'(dz3_reg) <<< shamt;
    end

    always_ff @(posedge aclk) begin
        if (r4 && v3_reg) begin
            dx4_reg    <= dx4_next;
            dy4_reg    <= dy4_next;
            dz4_reg    <= dz4_next;
            flags4_reg <= flags3_reg;
        end
    end

    // Stage 5: fold the left half-plane by a half turn
    cordic_t stage5_reg, stage5_next;

    always_comb begin
        stage5_next.x     = CW'(dx4_reg);
        stage5_next.y     = CW'(dz4_reg);
        stage5_next.z     = '0;
        stage5_next.aux   = dy4_reg;
        stage5_next.flags = flags4_reg;
        if (dx4_reg[AW-1]) begin
            stage5_next.x = -CW'(dx4_reg);
            stage5_next.y = -CW'(dz4_reg);
            stage5_next.z = dz4_reg[AW-1] ? -HALF_TURN : HALF_TURN;
        end
    end

    always_ff @(posedge aclk) begin
        if (r5 && v4_reg) begin
            stage5_reg <= stage5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = stage5_reg;

endmodule

// ===== hdl/stcw_cordic_step.sv =====
`timescale 1ns / 1ps

module stcw_cordic_step import stcw_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  cordic_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cordic_t out_data
);

    logic signed [CW-1:0] x_in, y_in, xs, ys;
    logic signed [AW-1:0] z_in;
    cordic_t stage_reg, stage_next;
    logic    valid_reg;

    assign in_ready = !valid_reg || out_ready;

    // Rotate toward y = 0; y >= 0 counts as positive
    always_comb begin
        x_in = in_data.x;
        y_in = in_data.y;
        z_in = in_data.z;
        xs   = x_in >>> SHIFT;
        ys   = y_in >>> SHIFT;
        stage_next = in_data;
        if (!y_in[CW-1]) begin
            stage_next.x = x_in + ys;
            stage_next.y = y_in - xs;
            stage_next.z = z_in + ATAN_BAM[SHIFT];
        end else begin
            stage_next.x = x_in - ys;
            stage_next.y = y_in + xs;
            stage_next.z = z_in - ATAN_BAM[SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = stage_reg;

endmodule

// ===== hdl/stcw_gain.sv =====
`timescale 1ns / 1ps

module stcw_gain import stcw_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  cordic_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cordic_t out_data
);

    // x after the yaw pass is nonnegative and below 2^34
    localparam int HALF_W = 17;
    localparam int PP_W   = HALF_W + 28;
    localparam int SUM_W  = PP_W + HALF_W + 1;

    logic v1_reg, v2_reg;
    logic r1, r2;

    assign r2 = !v2_reg || out_ready;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
        end
    end

    // Stage 1: two partial products of x * (1/K)
    logic [PP_W-1:0] plo_reg, phi_reg, plo_next, phi_next;
    logic signed [AW-1:0] yaw1_reg, dy1_reg;
    flags_t flags1_reg;
    logic [2*HALF_W-1:0] xu;

    always_comb begin
        xu       = in_data.x[2*HALF_W-1:0];
        plo_next = PP_W'(xu[HALF_W-1:0]) * PP_W'(INV_GAIN_Q28);
        phi_next = PP_W'(xu[2*HALF_W-1:HALF_W]) * PP_W'(INV_GAIN_Q28);
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) begin
            plo_reg    <= plo_next;
            phi_reg    <= phi_next;
            yaw1_reg   <= in_data.z;
            dy1_reg    <= in_data.aux;
            flags1_reg <= in_data.flags;
        end
    end

    // Stage 2: combine, round half up, start the pitch pass on (hypot, dy)
    logic [SUM_W-1:0] sum;
    cordic_t stage2_reg, stage2_next;

    always_comb begin
        sum = (SUM_W'(phi_reg) << HALF_W) + SUM_W'(plo_reg) + (SUM_W'(1) << 27);
        stage2_next.x     = CW'(sum[SUM_W-1:28]);
        stage2_next.y     = CW'(dy1_reg);
        stage2_next.z     = '0;
        stage2_next.aux   = yaw1_reg;
        stage2_next.flags = flags1_reg;
    end

    always_ff @(posedge aclk) begin
        if (r2 && v1_reg) begin
            stage2_reg <= stage2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = stage2_reg;

endmodule

// ===== hdl/stcw_out.sv =====
`timescale 1ns / 1ps

module stcw_out import stcw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  cordic_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] tex_u,
    output logic [15:0] tex_v,
    output logic        degenerate
);

    logic signed [AW-1:0] yaw, pitch;
    logic signed [AW:0]   tu, tv;
    logic [15:0] u_next, v_next, u_reg, v_reg;
    logic        degen_next, degen_reg;
    logic        valid_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        yaw   = in_data.aux;
        pitch = in_data.z;
        // pure Y offset: yaw zero, pitch at a pole
        if (in_data.flags.yaxis) begin
            yaw   = '0;
            pitch = in_data.flags.pitch_up ? QUARTER_TURN : -QUARTER_TURN;
        end
        tu = (AW+1)'(yaw) + (AW+1)'(HALF_TURN) + (AW+1)'(1 << 15);
        tv = (AW+1)'(pitch) + (AW+1)'(QUARTER_TURN) + (AW+1)'(1 << 14);

        if (tu[AW]) u_next = 16'd0;
        else if (|tu[AW-1:32]) u_next = 16'hFFFF;
        else u_next = tu[31:16];

        if (tv[AW]) v_next = 16'd0;
        else if (|tv[AW-1:31]) v_next = 16'hFFFF;
        else v_next = tv[30:15];

        degen_next = in_data.flags.degen;
        if (in_data.flags.degen) begin
            u_next = 16'h8000;
            v_next = 16'h8000;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            u_reg     <= u_next;
            v_reg     <= v_next;
            degen_reg <= degen_next;
        end
    end

    assign out_valid  = valid_reg;
    assign tex_u      = u_reg;
    assign tex_v      = v_reg;
    assign degenerate = degen_reg;

endmodule

// ===== hdl/spherical_texcoord_wrap.sv =====
// Spherical-wrap texture coordinates: each vertex (point_x/y/z) is offset by the
// configured center, and the block returns u = yaw/(2 pi) + 1/2 and v = pitch/pi + 1/2
// as unsigned Q0.16 (1.0 saturates to 65535); a vertex at the center gives one half
// for both and sets tuser. One vertex is accepted per clock unless the pipeline is
// full with m_tready low, and results come out in order through five front stages
// (offset, magnitude, leading-zero count, normalize, quadrant fold), one stage per
// CORDIC micro-rotation for yaw and again for pitch, two stages for the gain multiply,
// and the output register. Every stage has its own valid bit, so bubbles close up and
// s_tready stays high while the pipeline has a free slot even when m_tready is low.
// The center registers are written through the cfg channel (index 0..2 = x, y, z),
// which is always ready; write them only while the pipeline is empty.
`timescale 1ns / 1ps

module spherical_texcoord_wrap import stcw_pkg::*; #(
    parameter int ANGLE_ITERATIONS = 16,
    parameter int COORD_BITS       = 24
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // config write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]                  cfg_index,
    input  logic [COORD_BITS-1:0]                   cfg_data,
    // vertex in
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // point_x, point_y, point_z, zero pad to bytes
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    // result out
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // tex_u [15:0], tex_v [31:16]
    output logic [31:0]                             m_tdata,
    // degenerate
    output logic                                    m_tuser
);

    localparam int N = (ANGLE_ITERATIONS > ANG_TABLE_LEN) ? ANG_TABLE_LEN
                                                          : ANGLE_ITERATIONS;

    logic signed [COORD_BITS-1:0] center_x_reg, center_y_reg, center_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_CENTER_Z: center_z_reg <= cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    cordic_t yaw_data   [N+1];
    logic    yaw_valid  [N+1];
    logic    yaw_ready  [N+1];
    cordic_t pit_data   [N+1];
    logic    pit_valid  [N+1];
    logic    pit_ready  [N+1];

    stcw_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .center_z  (center_z_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .point_x   (s_tdata[COORD_BITS-1:0]),
        .point_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .point_z   (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .out_valid (yaw_valid[0]),
        .out_ready (yaw_ready[0]),
        .out_data  (yaw_data[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_yaw
        stcw_cordic_step #(
            .SHIFT (g)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (yaw_valid[g]),
            .in_ready  (yaw_ready[g]),
            .in_data   (yaw_data[g]),
            .out_valid (yaw_valid[g+1]),
            .out_ready (yaw_ready[g+1]),
            .out_data  (yaw_data[g+1])
        );
    end

    stcw_gain u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (yaw_valid[N]),
        .in_ready  (yaw_ready[N]),
        .in_data   (yaw_data[N]),
        .out_valid (pit_valid[0]),
        .out_ready (pit_ready[0]),
        .out_data  (pit_data[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_pitch
        stcw_cordic_step #(
            .SHIFT (g)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (pit_valid[g]),
            .in_ready  (pit_ready[g]),
            .in_data   (pit_data[g]),
            .out_valid (pit_valid[g+1]),
            .out_ready (pit_ready[g+1]),
            .out_data  (pit_data[g+1])
        );
    end

    stcw_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (pit_valid[N]),
        .in_ready   (pit_ready[N]),
        .in_data    (pit_data[N]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .tex_u      (m_tdata[15:0]),
        .tex_v      (m_tdata[31:16]),
        .degenerate (m_tuser)
    );

endmodule
